[sv/tla_pkg.sv]
package tla_pkg;

    // input func codes
    localparam logic [1:0] FUNC_TOGGLE = 2'd0;
    localparam logic [1:0] FUNC_STEP   = 2'd1;
    localparam logic [1:0] FUNC_READ   = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // B3/S23 rule counts
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] SURVIVE_LOW = 4'd2;

    // config register indexes
    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int COORD_W = 6;
    localparam int CFG_W   = 7;

    // classified command handed from front to back
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic               oor;
        logic [COORD_W-1:0] x_position;
        logic [COORD_W-1:0] y_position;
    } cmd_t;

    // one-bit rule for a cell given its live neighbor count
    function automatic logic next_cell(input logic alive, input logic [3:0] cnt);
        if (alive) begin
            return (cnt == SURVIVE_LOW) || (cnt == BIRTH_COUNT);
        end
        return cnt == BIRTH_COUNT;
    endfunction

endpackage

[sv/tla_front.sv]
module tla_front #(
    parameter int WW = 7,
    parameter int HW = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [WW-1:0]        grid_w,
    input  logic [HW-1:0]        grid_h,
    input  logic                 hold,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,
    output logic                 cmd_valid,
    output tla_pkg::cmd_t        cmd,
    input  logic                 cmd_pop
);

    tla_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    cnt_reg, cnt_next;
    tla_pkg::cmd_t in_cmd;
    logic          push;

    // classify the incoming item
    always_comb begin
        in_cmd.func       = s_tdata[1:0];
        in_cmd.x_position = s_tdata[7:2];
        in_cmd.y_position = s_tdata[13:8];
        in_cmd.oor        = 1'b0;
        if (in_cmd.func == tla_pkg::FUNC_TOGGLE || in_cmd.func == tla_pkg::FUNC_READ) begin
            in_cmd.oor = (int'(in_cmd.x_position) >= int'(grid_w)) ||
                         (int'(in_cmd.y_position) >= int'(grid_h));
        end
    end

    assign s_tready  = !hold && (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = cnt_reg != 2'd0;
    assign cmd       = q_reg[rd_ptr_reg];

    // two-entry queue pointers
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue payload
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[sv/tla_back.sv]
module tla_back #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int WW         = 7,
    parameter int HW         = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [WW-1:0]        grid_w,
    input  logic [HW-1:0]        grid_h,
    output logic                 clearing,
    input  logic                 cmd_valid,
    input  tla_pkg::cmd_t        cmd,
    output logic                 cmd_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata
);

    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW = RW + 1;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_ACC      = 3'd2;
    localparam logic [2:0] S_ACC_DONE = 3'd3;
    localparam logic [2:0] S_GEN_RD   = 3'd4;
    localparam logic [2:0] S_GEN_WR   = 3'd5;
    localparam logic [2:0] S_GEN_FLIP = 3'd6;

    // row store: address is {bank, row}
    logic [MAX_WIDTH-1:0] mem [2**AW];
    logic [MAX_WIDTH-1:0] rd_data_reg;
    logic [AW-1:0]        mem_raddr, mem_waddr;
    logic [MAX_WIDTH-1:0] mem_wdata;
    logic                 mem_we;

    logic [2:0]           state_reg, state_next;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [MAX_HEIGHT-1:0] bank_reg, bank_next;
    logic [RW-1:0]        gy_reg, gy_next;
    logic [1:0]           ph_reg, ph_next;
    logic [MAX_WIDTH-1:0] win_reg [3];
    tla_pkg::cmd_t        cur_reg, cur_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_alive_reg, out_alive_next;
    logic                 out_oor_reg, out_oor_next;

    logic [RW-1:0]        acc_row, ym, yp, rd_row;
    logic [CW-1:0]        acc_col, wlast;
    logic                 gy_last, out_free;
    logic [MAX_WIDTH-1:0] gen_row;

    assign out_free = !out_valid_reg || m_tready;
    assign clearing = state_reg == S_CLEAR;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_oor_reg, out_alive_reg};

    assign acc_row = RW'(cur_reg.y_position);
    assign acc_col = CW'(cur_reg.x_position);
    assign wlast   = CW'(int'(grid_w) - 1);
    assign gy_last = int'(gy_reg) == int'(grid_h) - 1;
    assign ym      = (gy_reg == '0) ? RW'(int'(grid_h) - 1) : gy_reg - 1'b1;
    assign yp      = gy_last ? '0 : gy_reg + 1'b1;

    // next generation of the row in the window middle
    always_comb begin
        logic [3:0] cnt;
        int         xm, xp;
        gen_row = '0;
        for (int x = 0; x < MAX_WIDTH; x++) begin
            xm  = (x == 0) ? 0 : x - 1;
            xp  = (x == MAX_WIDTH - 1) ? 0 : x + 1;
            cnt = '0;
            for (int r = 0; r < 3; r++) begin
                if (x == 0) begin
                    cnt = cnt + 4'(win_reg[r][wlast]);
                end else begin
                    cnt = cnt + 4'(win_reg[r][xm]);
                end
                if (CW'(x) == wlast) begin
                    cnt = cnt + 4'(win_reg[r][0]);
                end else begin
                    cnt = cnt + 4'(win_reg[r][xp]);
                end
                if (r != 1) begin
                    cnt = cnt + 4'(win_reg[r][x]);
                end
            end
            if (x < int'(grid_w)) begin
                gen_row[x] = tla_pkg::next_cell(win_reg[1][x], cnt);
            end else begin
                gen_row[x] = win_reg[1][x];
            end
        end
    end

    // window read row by phase
    always_comb begin
        case (ph_reg)
            2'd0:    rd_row = ym;
            2'd1:    rd_row = gy_reg;
            default: rd_row = yp;
        endcase
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        bank_next      = bank_reg;
        gy_next        = gy_reg;
        ph_next        = ph_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_alive_next = out_alive_reg;
        out_oor_next   = out_oor_reg;
        cmd_pop        = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = clr_reg;
        mem_wdata      = '0;
        mem_raddr      = {bank_reg[acc_row], acc_row};
        case (state_reg)
            S_CLEAR: begin
                mem_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_pop  = 1'b1;
                    cur_next = cmd;
                    if (cmd.func == tla_pkg::FUNC_STEP) begin
                        gy_next    = '0;
                        ph_next    = '0;
                        state_next = S_GEN_RD;
                    end else if (cmd.oor || cmd.func == tla_pkg::FUNC_NONE) begin
                        out_valid_next = 1'b1;
                        out_alive_next = 1'b0;
                        out_oor_next   = cmd.oor;
                    end else begin
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC: begin
                // read issued from mem_raddr default
                state_next = S_ACC_DONE;
            end
            S_ACC_DONE: begin
                mem_wdata          = rd_data_reg;
                mem_wdata[acc_col] = ~rd_data_reg[acc_col];
                mem_waddr          = {bank_reg[acc_row], acc_row};
                mem_we             = cur_reg.func == tla_pkg::FUNC_TOGGLE;
                out_valid_next     = 1'b1;
                out_alive_next     = mem_we ? mem_wdata[acc_col] : rd_data_reg[acc_col];
                out_oor_next       = 1'b0;
                state_next         = S_IDLE;
            end
            S_GEN_RD: begin
                mem_raddr = {bank_reg[rd_row], rd_row};
                ph_next   = ph_reg + 1'b1;
                if (ph_reg == 2'd3) begin
                    state_next = S_GEN_WR;
                end
            end
            S_GEN_WR: begin
                mem_we    = 1'b1;
                mem_waddr = {~bank_reg[gy_reg], gy_reg};
                mem_wdata = gen_row;
                ph_next   = '0;
                if (gy_last) begin
                    state_next = S_GEN_FLIP;
                end else begin
                    gy_next    = gy_reg + 1'b1;
                    state_next = S_GEN_RD;
                end
            end
            S_GEN_FLIP: begin
                for (int r = 0; r < MAX_HEIGHT; r++) begin
                    if (r < int'(grid_h)) begin
                        bank_next[r] = ~bank_reg[r];
                    end
                end
                out_valid_next = 1'b1;
                out_alive_next = 1'b0;
                out_oor_next   = 1'b0;
                state_next     = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            bank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            bank_reg      <= bank_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and window capture
    always_ff @(posedge aclk) begin
        gy_reg        <= gy_next;
        ph_reg        <= ph_next;
        cur_reg       <= cur_next;
        out_alive_reg <= out_alive_next;
        out_oor_reg   <= out_oor_next;
        if (state_reg == S_GEN_RD && ph_reg != 2'd0) begin
            win_reg[ph_reg - 2'd1] <= rd_data_reg;
        end
    end

    // row store ports
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

endmodule

[sv/toroidal_life_automaton.sv]
// Channel   Dir  Payload (tdata, lowest bit first)
// s_axis    in   func[1:0], x_position[7:2], y_position[13:8], zeros to 16
// m_axis    out  cell_alive[0], out_of_range[1], zeros to 8
// cfg       in   cfg_index 0 grid_width, 1 grid_height; cfg_wdata 7 bits
//
// Toggle and read pass S_ACC and S_ACC_DONE in the back end; out-of-grid and unused
// codes are answered from idle. A generation runs dispatch, then per row the read
// phases (three row reads, last capture) and one row write, then the bank flip.
// After reset a clearing pass writes all 2*2^ceil(log2(MAX_HEIGHT)) store rows
// (128 by default) with s_tready low; config writes are taken.
// A two-entry queue splits accept from execution; a held result stalls the back end.
module toroidal_life_automaton #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // func, x_position, y_position
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // cell_alive, out_of_range
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [tla_pkg::CFG_W-1:0] cfg_wdata
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [WW-1:0]  grid_w_reg;
    logic [HW-1:0]  grid_h_reg;
    logic           clearing, cmd_valid, cmd_pop;
    tla_pkg::cmd_t  cmd;

    // size registers, saturated to 1..max
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_w_reg <= WW'((MAX_WIDTH < 64) ? MAX_WIDTH : 64);
            grid_h_reg <= HW'((MAX_HEIGHT < 64) ? MAX_HEIGHT : 64);
        end else if (cfg_wr_en) begin
            if (cfg_index == tla_pkg::CFG_WIDTH) begin
                if (cfg_wdata == '0) begin
                    grid_w_reg <= WW'(1);
                end else if (int'(cfg_wdata) > MAX_WIDTH) begin
                    grid_w_reg <= WW'(MAX_WIDTH);
                end else begin
                    grid_w_reg <= WW'(cfg_wdata);
                end
            end else begin
                if (cfg_wdata == '0) begin
                    grid_h_reg <= HW'(1);
                end else if (int'(cfg_wdata) > MAX_HEIGHT) begin
                    grid_h_reg <= HW'(MAX_HEIGHT);
                end else begin
                    grid_h_reg <= HW'(cfg_wdata);
                end
            end
        end
    end

    tla_front #(
        .WW (WW),
        .HW (HW)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grid_w    (grid_w_reg),
        .grid_h    (grid_h_reg),
        .hold      (clearing),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    tla_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .WW         (WW),
        .HW         (HW)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .grid_w    (grid_w_reg),
        .grid_h    (grid_h_reg),
        .clearing  (clearing),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int GRID_MAX    = 64;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 400;   // longer than the longest generation

    typedef enum logic { ROW_ITEM, ROW_RESIZE } row_kind_t;

    typedef struct {
        row_kind_t                  kind;
        logic [tla_pkg::FUNC_W-1:0] func;
        logic [6:0]                 xv;      // x, or width on a resize
        logic [6:0]                 yv;      // y, or height on a resize
        bit                         typed;
        bit                         alive;
        bit                         oor;
    } stim_row_t;

    typedef struct {
        bit alive;
        bit oor;
    } life_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = tla_pkg::CFG_WIDTH;
    logic [tla_pkg::CFG_W-1:0] cfg_wdata = '0;

    // model state: cells indexed [row][column]
    bit             board [GRID_MAX][GRID_MAX];
    int             cols_in_use;
    int             rows_in_use;
    life_result_t   pending_results [$];

    int  mismatches = 0;
    int  cycles = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  generations = 0;
    int  oor_seen = 0;
    int  send_idle_pct = 25;
    int  recv_stall_pct = 76;
    int  hold_request = 0;
    int  hold_left = 0;

    toroidal_life_automaton dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // func[1:0], x_position[7:2], y_position[13:8]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // cell_alive[0], out_of_range[1]
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("toroidal_life_automaton regression: fail");
            $finish;
        end
    end

    function automatic int clamp_size(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > GRID_MAX) return GRID_MAX;
        return v;
    endfunction

    // one B3/S23 generation over the area in use, wrapping at its edges
    function automatic void advance_board();
        bit nxt [GRID_MAX][GRID_MAX];
        int n;
        nxt = board;
        for (int r = 0; r < rows_in_use; r++) begin
            for (int c = 0; c < cols_in_use; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0)
                            n += board[(r + rows_in_use + dr) % rows_in_use]
                                      [(c + cols_in_use + dc) % cols_in_use];
                    end
                end
                nxt[r][c] = board[r][c] ? (n == 2 || n == 3) : (n == 3);
            end
        end
        board = nxt;
    endfunction

    // result of one accepted transfer, updating the model
    function automatic life_result_t predict_cell(input logic [tla_pkg::FUNC_W-1:0] func,
                                                  input int xp, input int yp);
        life_result_t res;
        res = '{alive: 0, oor: 0};
        if (func == tla_pkg::FUNC_STEP) begin
            advance_board();
        end else if (func == tla_pkg::FUNC_TOGGLE || func == tla_pkg::FUNC_READ) begin
            if (xp >= cols_in_use || yp >= rows_in_use) begin
                res.oor = 1;
            end else begin
                if (func == tla_pkg::FUNC_TOGGLE) board[yp][xp] = ~board[yp][xp];
                res.alive = board[yp][xp];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // result side: check each transfer, then pick tready for the next edge
    always @(posedge aclk) begin
        life_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, -1);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.alive) report_mismatch("cell_alive", m_tdata[0], want.alive);
                if (m_tdata[1] !== want.oor) report_mismatch("out_of_range", m_tdata[1], want.oor);
                if (m_tdata[7:2] !== 6'd0) report_mismatch("tdata padding", m_tdata[7:2], 0);
            end
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic [tla_pkg::FUNC_W-1:0] func, input logic [5:0] xp,
                             input logic [5:0] yp, input bit typed,
                             input bit alive, input bit oor);
        life_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, yp, xp, func};
        do @(posedge aclk); while (!s_tready);
        res = predict_cell(func, xp, yp);
        if (typed) res = '{alive: alive, oor: oor};
        pending_results.push_back(res);
        items_sent++;
        if (func == tla_pkg::FUNC_STEP) generations++;
        if (res.oor) oor_seen++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // both size registers; only called with the block idle
    task automatic resize(input logic [6:0] w, input logic [6:0] h);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= tla_pkg::CFG_WIDTH;
        cfg_wdata <= w;
        @(posedge aclk);
        cols_in_use = clamp_size(w);
        cfg_index <= tla_pkg::CFG_HEIGHT;
        cfg_wdata <= h;
        @(posedge aclk);
        rows_in_use = clamp_size(h);
        cfg_wr_en <= 1'b0;
    endtask

    // random transfer, biased toward cells inside the area in use
    task automatic send_random(input int step_pct);
        int pick;
        logic [tla_pkg::FUNC_W-1:0] func;
        logic [5:0] xp, yp;
        pick = $urandom_range(99);
        if (pick < step_pct) func = tla_pkg::FUNC_STEP;
        else if (pick < step_pct + 4) func = tla_pkg::FUNC_NONE;
        else if (pick < step_pct + 50) func = tla_pkg::FUNC_TOGGLE;
        else func = tla_pkg::FUNC_READ;
        if ($urandom_range(99) < 20) begin
            xp = 6'($urandom);
            yp = 6'($urandom);
        end else begin
            xp = 6'($urandom_range(cols_in_use - 1));
            yp = 6'($urandom_range(rows_in_use - 1));
        end
        send_item(func, xp, yp, 0, 0, 0);
    endtask

    stim_row_t directed [] = '{
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   0,  0,  1, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   63, 63, 1, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_TOGGLE, 63, 63, 1, 1, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   63, 63, 1, 1, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_TOGGLE, 0,  0,  1, 1, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_TOGGLE, 0,  63, 1, 1, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_TOGGLE, 63, 0,  1, 1, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_NONE,   21, 42, 1, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_STEP,   0,  0,  1, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   0,  0,  0, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_TOGGLE, 10, 9,  0, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_TOGGLE, 10, 10, 0, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_TOGGLE, 10, 11, 0, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_STEP,   0,  0,  1, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   9,  10, 0, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   10, 9,  0, 0, 0},
        '{ROW_RESIZE, tla_pkg::FUNC_NONE,   0,  0,  0, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_TOGGLE, 1,  0,  1, 0, 1},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   0,  1,  1, 0, 1},
        '{ROW_ITEM,   tla_pkg::FUNC_STEP,   0,  0,  1, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   0,  0,  0, 0, 0},
        '{ROW_RESIZE, tla_pkg::FUNC_NONE,   127, 2, 0, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   63, 2,  1, 0, 1},
        '{ROW_ITEM,   tla_pkg::FUNC_STEP,   0,  0,  1, 0, 0},
        '{ROW_ITEM,   tla_pkg::FUNC_READ,   63, 63, 0, 0, 0}
    };

    initial begin
        cols_in_use = GRID_MAX;
        rows_in_use = GRID_MAX;
        foreach (board[r, c]) board[r][c] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_RESIZE)
                resize(directed[i].xv, directed[i].yv);
            else
                send_item(directed[i].func, 6'(directed[i].xv), 6'(directed[i].yv),
                          directed[i].typed, directed[i].alive, directed[i].oor);
        end

        // small torus, long receiver hold-off, then a full pause
        resize(7'd7, 7'd6);
        hold_request = 300;
        for (int i = 0; i < 30; i++) send_random(12);
        drain();
        for (int i = 0; i < 15; i++) send_random(12);

        // roles swapped
        send_idle_pct = 76;
        recv_stall_pct = 25;
        resize(7'd2, 7'd64);
        for (int i = 0; i < 25; i++) send_random(10);
        resize(7'd64, 7'd64);
        for (int i = 0; i < 15; i++) send_random(4);

        // no idling
        send_idle_pct = 0;
        recv_stall_pct = 0;
        resize(7'd64, 7'd3);
        for (int i = 0; i < 20; i++) send_random(10);
        resize(7'd5, 7'd5);
        for (int i = 0; i < 20; i++) send_random(15);
        drain();

        $display("covered %0d transfers, %0d results, %0d generations, %0d out-of-grid",
                 items_sent, results_seen, generations, oor_seen);
        $display("sizes from 1x1 to 64x64 incl. saturated writes, three idle profiles");
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("toroidal_life_automaton regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
            $display("toroidal_life_automaton regression: fail");
        end
        $finish;
    end

endmodule
